// File: rtl/core/vvr_pkg.sv
// ----------------------------------------------------------------------------
// vvr_pkg
// Shared widths, register indexes and the rounding helper of the rotator.
// ----------------------------------------------------------------------------
package vvr_pkg;

  localparam int FIELD_W   = 18;
  localparam int NUM_REGS  = 6;
  localparam int CFG_IDX_W = 3;
  localparam int MUL_W     = 33;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int CROSS_W   = 38;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FROM_X = 3'd0,
    REG_FROM_Y = 3'd1,
    REG_FROM_Z = 3'd2,
    REG_TO_X   = 3'd3,
    REG_TO_Y   = 3'd4,
    REG_TO_Z   = 3'd5
  } reg_idx_t;

  // Drops sh fraction bits, rounding half away from zero.
  function automatic logic signed [PROD_W-1:0] rnd_shift(input logic signed [PROD_W-1:0] v,
                                                          input int unsigned sh);
    logic             neg;
    logic [PROD_W-1:0] mag;
    neg = v[PROD_W-1];
    mag = neg ? PROD_W'(-v) : PROD_W'(v);
    if (sh > 0) begin
      mag = (mag + (PROD_W'(1) << (sh - 1))) >> sh;
    end
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

// File: rtl/core/vvr_if.sv
// ----------------------------------------------------------------------------
// vvr_if
// Point, result and configuration channels of the rotator.
// ----------------------------------------------------------------------------
interface vvr_point_if;
  logic                                valid;
  logic                                ready;
  logic signed [vvr_pkg::FIELD_W-1:0] in_x;
  logic signed [vvr_pkg::FIELD_W-1:0] in_y;
  logic signed [vvr_pkg::FIELD_W-1:0] in_z;
  modport source(output valid, in_x, in_y, in_z, input ready);
  modport sink(input valid, in_x, in_y, in_z, output ready);
endinterface

interface vvr_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [vvr_pkg::FIELD_W-1:0] out_x;
  logic signed [vvr_pkg::FIELD_W-1:0] out_y;
  logic signed [vvr_pkg::FIELD_W-1:0] out_z;
  modport source(output valid, out_x, out_y, out_z, input ready);
  modport sink(input valid, out_x, out_y, out_z, output ready);
endinterface

interface vvr_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [vvr_pkg::CFG_IDX_W-1:0]       index;
  logic [vvr_pkg::FIELD_W-1:0]         data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: rtl/core/vvr_isqrt.sv
// ----------------------------------------------------------------------------
// vvr_isqrt
// Integer square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module vvr_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] n,
  output logic        done,
  output logic [31:0] root
);

  logic        run;
  logic [63:0] rem;
  logic [63:0] res;
  logic [63:0] bitr;
  logic [63:0] trial;

  assign trial = res + bitr;
  assign root  = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        rem  <= n;
        res  <= '0;
        bitr <= 64'(1) << 62;
      end else if (run) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          res <= (res >> 1) + bitr;
        end else begin
          res <= res >> 1;
        end
        bitr <= bitr >> 2;
        if (bitr[0]) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/core/vvr_div.sv
// ----------------------------------------------------------------------------
// vvr_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vvr_div #(
  parameter int QBITS = 18
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [63:0]      num,
  input  logic [31:0]      den,
  output logic             done,
  output logic [QBITS-1:0] quot
);

  localparam int CW = $clog2(QBITS);

  logic          run;
  logic [63:0]   rem;
  logic [63:0]   dsh;
  logic [CW-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        rem  <= num;
        dsh  <= 64'(den) << (QBITS - 1);
        quot <= '0;
        cnt  <= CW'(QBITS - 1);
      end else if (run) begin
        if (rem >= dsh) begin
          rem  <= rem - dsh;
          quot <= {quot[QBITS-2:0], 1'b1};
        end else begin
          quot <= {quot[QBITS-2:0], 1'b0};
        end
        dsh <= dsh >> 1;
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/core/vvr_setup.sv
// ----------------------------------------------------------------------------
// vvr_setup
// Builds the rotation matrix from the two configured vectors with one shared
// multiplier, a square root unit and a divider.
// ----------------------------------------------------------------------------
module vvr_setup #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [vvr_pkg::FIELD_W-1:0]  vec [vvr_pkg::NUM_REGS],
  output logic                                ready,
  output logic signed [FRAC_BITS+2:0]         mat [9]
);

  localparam int UW = FRAC_BITS + 2;
  localparam int TW = FRAC_BITS + 3;
  localparam int EW = FRAC_BITS + 3;
  localparam int MW = vvr_pkg::MUL_W;
  localparam int PW = vvr_pkg::PROD_W;
  localparam int CRW = vvr_pkg::CROSS_W;
  localparam logic signed [UW-1:0] ONE_U = {2'b01, {FRAC_BITS{1'b0}}};
  localparam logic signed [PW-1:0] ONE_P = PW'(ONE_U);

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_MUL, S_DRAIN, S_CHECK, S_NORM, S_SQM_GO, S_SQM_WAIT,
    S_SQS_GO, S_SQS_WAIT, S_DIV_GO, S_DIV_WAIT, S_FIN
  } state_t;

  state_t                  state;
  logic [4:0]              k;
  logic [4:0]              wb_k;
  logic                    wb_v;
  logic signed [PW-1:0]    prod;
  logic signed [MW-1:0]    op_a;
  logic signed [MW-1:0]    op_b;
  logic signed [CRW-1:0]   cr [3];
  logic signed [CRW-1:0]   dot;
  logic [35:0]             a [3];
  logic [63:0]             sumsq;
  logic [2*FRAC_BITS:0]    cc;
  logic [31:0]             m;
  logic [FRAC_BITS:0]      s;
  logic signed [UW-1:0]    u [3];
  logic [1:0]              j;
  logic signed [UW-1:0]    p [6];
  logic signed [UW-1:0]    w [3];
  logic signed [TW-1:0]    e [6];
  logic signed [PW-1:0]    c_full;
  logic signed [PW-1:0]    mulf;
  logic signed [UW-1:0]    c;
  logic signed [TW-1:0]    t;
  logic signed [MW-1:0]    s_op;
  logic                    sq_start;
  logic [63:0]             sq_n;
  logic                    sq_done;
  logic [31:0]             sq_root;
  logic                    dv_start;
  logic [63:0]             dv_num;
  logic                    dv_done;
  logic [UW-1:0]           dv_q;
  logic [UW-1:0]           qc;
  logic                    any_hi;
  logic                    all_lo;

  assign c_full = vvr_pkg::rnd_shift(PW'(dot), FRAC_BITS);
  assign c      = (c_full > ONE_P) ? ONE_U : ((c_full < -ONE_P) ? -ONE_U : UW'(c_full));
  assign t      = TW'(ONE_U) - TW'(c);
  assign s_op   = $signed({{(MW - FRAC_BITS - 1){1'b0}}, s});
  assign mulf   = vvr_pkg::rnd_shift(prod, FRAC_BITS);

  assign any_hi = (|a[0][35:30]) | (|a[1][35:30]) | (|a[2][35:30]);
  assign all_lo = ~((|a[0][35:29]) | (|a[1][35:29]) | (|a[2][35:29]));

  assign sq_start = (state == S_SQM_GO) || (state == S_SQS_GO);
  assign sq_n     = (state == S_SQM_GO) ? sumsq
                                        : ((64'(1) << (2 * FRAC_BITS)) - 64'(cc));
  assign dv_start = (state == S_DIV_GO);
  assign dv_num   = (64'(a[j][29:0]) << FRAC_BITS) + 64'(m >> 1);
  assign qc       = (dv_q > UW'(ONE_U)) ? UW'(ONE_U) : dv_q;

  always_comb begin
    case (k)
      5'd0:    begin op_a = MW'(vec[2]); op_b = MW'(vec[4]); end
      5'd1:    begin op_a = MW'(vec[1]); op_b = MW'(vec[5]); end
      5'd2:    begin op_a = MW'(vec[0]); op_b = MW'(vec[5]); end
      5'd3:    begin op_a = MW'(vec[2]); op_b = MW'(vec[3]); end
      5'd4:    begin op_a = MW'(vec[1]); op_b = MW'(vec[3]); end
      5'd5:    begin op_a = MW'(vec[0]); op_b = MW'(vec[4]); end
      5'd6:    begin op_a = MW'(vec[0]); op_b = MW'(vec[3]); end
      5'd7:    begin op_a = MW'(vec[1]); op_b = MW'(vec[4]); end
      5'd8:    begin op_a = MW'(vec[2]); op_b = MW'(vec[5]); end
      5'd9:    begin op_a = $signed(MW'(a[0][29:0])); op_b = $signed(MW'(a[0][29:0])); end
      5'd10:   begin op_a = $signed(MW'(a[1][29:0])); op_b = $signed(MW'(a[1][29:0])); end
      5'd11:   begin op_a = $signed(MW'(a[2][29:0])); op_b = $signed(MW'(a[2][29:0])); end
      5'd12:   begin op_a = MW'(c); op_b = MW'(c); end
      5'd13:   begin op_a = MW'(u[0]); op_b = MW'(u[0]); end
      5'd14:   begin op_a = MW'(u[0]); op_b = MW'(u[1]); end
      5'd15:   begin op_a = MW'(u[0]); op_b = MW'(u[2]); end
      5'd16:   begin op_a = MW'(u[1]); op_b = MW'(u[1]); end
      5'd17:   begin op_a = MW'(u[1]); op_b = MW'(u[2]); end
      5'd18:   begin op_a = MW'(u[2]); op_b = MW'(u[2]); end
      5'd19:   begin op_a = MW'(u[0]); op_b = s_op; end
      5'd20:   begin op_a = MW'(u[1]); op_b = s_op; end
      5'd21:   begin op_a = MW'(u[2]); op_b = s_op; end
      5'd22:   begin op_a = MW'(p[0]); op_b = MW'(t); end
      5'd23:   begin op_a = MW'(p[1]); op_b = MW'(t); end
      5'd24:   begin op_a = MW'(p[2]); op_b = MW'(t); end
      5'd25:   begin op_a = MW'(p[3]); op_b = MW'(t); end
      5'd26:   begin op_a = MW'(p[4]); op_b = MW'(t); end
      5'd27:   begin op_a = MW'(p[5]); op_b = MW'(t); end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
    if (state == S_CLEAR) begin
      cr[0] <= '0;
      cr[1] <= '0;
      cr[2] <= '0;
      dot   <= '0;
      sumsq <= '0;
    end else if (wb_v) begin
      case (wb_k) inside
        5'd0:    cr[0] <= cr[0] + $signed(prod[CRW-1:0]);
        5'd1:    cr[0] <= cr[0] - $signed(prod[CRW-1:0]);
        5'd2:    cr[1] <= cr[1] + $signed(prod[CRW-1:0]);
        5'd3:    cr[1] <= cr[1] - $signed(prod[CRW-1:0]);
        5'd4:    cr[2] <= cr[2] + $signed(prod[CRW-1:0]);
        5'd5:    cr[2] <= cr[2] - $signed(prod[CRW-1:0]);
        5'd6, 5'd7, 5'd8: dot <= dot + $signed(prod[CRW-1:0]);
        5'd9, 5'd10, 5'd11: sumsq <= sumsq + prod[63:0];
        5'd12:   cc <= prod[2*FRAC_BITS:0];
        5'd13:   p[0] <= UW'(mulf);
        5'd14:   p[1] <= UW'(mulf);
        5'd15:   p[2] <= UW'(mulf);
        5'd16:   p[3] <= UW'(mulf);
        5'd17:   p[4] <= UW'(mulf);
        5'd18:   p[5] <= UW'(mulf);
        5'd19:   w[0] <= UW'(mulf);
        5'd20:   w[1] <= UW'(mulf);
        5'd21:   w[2] <= UW'(mulf);
        5'd22:   e[0] <= TW'(mulf);
        5'd23:   e[1] <= TW'(mulf);
        5'd24:   e[2] <= TW'(mulf);
        5'd25:   e[3] <= TW'(mulf);
        5'd26:   e[4] <= TW'(mulf);
        5'd27:   e[5] <= TW'(mulf);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ready <= 1'b0;
      wb_v  <= 1'b0;
      k     <= '0;
      j     <= '0;
    end else begin
      wb_v <= (state == S_MUL);
      wb_k <= k;
      if (start) begin
        state <= S_CLEAR;
        ready <= 1'b0;
      end else begin
        unique case (state)
          S_IDLE: ;
          S_CLEAR: begin
            k     <= '0;
            state <= S_MUL;
          end
          S_MUL: begin
            k <= k + 1'b1;
            if (k == 5'd8 || k == 5'd12 || k == 5'd27) begin
              state <= S_DRAIN;
            end
          end
          S_DRAIN: begin
            if (k == 5'd9) begin
              state <= S_CHECK;
            end else if (k == 5'd13) begin
              state <= S_SQM_GO;
            end else begin
              state <= S_FIN;
            end
          end
          S_CHECK: begin
            if (cr[0] == '0 && cr[1] == '0 && cr[2] == '0) begin
              for (int i = 0; i < 9; i++) begin
                mat[i] <= (i == 0 || i == 4 || i == 8) ? EW'(ONE_U) : '0;
              end
              ready <= 1'b1;
              state <= S_IDLE;
            end else begin
              for (int i = 0; i < 3; i++) begin
                a[i] <= cr[i][CRW-1] ? 36'(-cr[i]) : 36'(cr[i]);
              end
              state <= S_NORM;
            end
          end
          S_NORM: begin
            if (any_hi) begin
              for (int i = 0; i < 3; i++) a[i] <= a[i] >> 1;
            end else if (all_lo) begin
              for (int i = 0; i < 3; i++) a[i] <= a[i] << 1;
            end else begin
              state <= S_MUL;
            end
          end
          S_SQM_GO: state <= S_SQM_WAIT;
          S_SQM_WAIT: begin
            if (sq_done) begin
              m     <= sq_root;
              state <= S_SQS_GO;
            end
          end
          S_SQS_GO: state <= S_SQS_WAIT;
          S_SQS_WAIT: begin
            if (sq_done) begin
              s     <= sq_root[FRAC_BITS:0];
              j     <= '0;
              state <= S_DIV_GO;
            end
          end
          S_DIV_GO: state <= S_DIV_WAIT;
          S_DIV_WAIT: begin
            if (dv_done) begin
              u[j] <= cr[j][CRW-1] ? -$signed(qc) : $signed(qc);
              j    <= j + 1'b1;
              state <= (j == 2'd2) ? S_MUL : S_DIV_GO;
            end
          end
          S_FIN: begin
            mat[0] <= EW'(c) + e[0];
            mat[1] <= e[1] + EW'(w[2]);
            mat[2] <= e[2] - EW'(w[1]);
            mat[3] <= e[1] - EW'(w[2]);
            mat[4] <= EW'(c) + e[3];
            mat[5] <= EW'(w[0]) + e[4];
            mat[6] <= e[2] + EW'(w[1]);
            mat[7] <= e[4] - EW'(w[0]);
            mat[8] <= EW'(c) + e[5];
            ready  <= 1'b1;
            state  <= S_IDLE;
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

  vvr_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .n     (sq_n),
    .done  (sq_done),
    .root  (sq_root)
  );

  vvr_div #(.QBITS(UW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dv_start),
    .num   (dv_num),
    .den   (m),
    .done  (dv_done),
    .quot  (dv_q)
  );

endmodule

// File: rtl/core/vvr_datapath.sv
// ----------------------------------------------------------------------------
// vvr_datapath
// Four-stage matrix-vector pipeline: capture, products, sums, round and
// saturate.
// ----------------------------------------------------------------------------
module vvr_datapath #(
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         run,
  input  logic signed [FRAC_BITS+2:0]  mat [9],
  vvr_point_if.sink                    point,
  vvr_result_if.source                 result
);

  localparam int FW = vvr_pkg::FIELD_W;
  localparam int EW = FRAC_BITS + 3;
  localparam int MPW = EW + FW;
  localparam int SW = MPW + 2;
  localparam int PW = vvr_pkg::PROD_W;
  localparam logic signed [PW-1:0] SAT_HI =
    (FRAC_BITS < FW - 1) ? (PW'(1) <<< FRAC_BITS) : PW'((1 << (FW - 1)) - 1);
  localparam logic signed [PW-1:0] SAT_LO =
    (FRAC_BITS < FW - 1) ? -(PW'(1) <<< FRAC_BITS) : -PW'(1 << (FW - 1));

  logic                   v1, v2, v3;
  logic                   en1, en2, en3, en4;
  logic signed [FW-1:0]   px [3];
  logic signed [MPW-1:0]  pr [9];
  logic signed [SW-1:0]   sm [3];
  logic signed [PW-1:0]   rv [3];
  logic signed [FW-1:0]   ox [3];

  assign en4 = !result.valid || result.ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign point.ready = en1 && run;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rv[i] = vvr_pkg::rnd_shift(PW'(sm[i]), FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (en1) v1 <= point.valid && point.ready;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) result.valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      px[0] <= point.in_x;
      px[1] <= point.in_y;
      px[2] <= point.in_z;
    end
    if (en2) begin
      for (int i = 0; i < 9; i++) begin
        pr[i] <= mat[i] * px[i % 3];
      end
    end
    if (en3) begin
      for (int i = 0; i < 3; i++) begin
        sm[i] <= SW'(pr[3*i]) + SW'(pr[3*i+1]) + SW'(pr[3*i+2]);
      end
    end
    if (en4) begin
      for (int i = 0; i < 3; i++) begin
        ox[i] <= (rv[i] > SAT_HI) ? FW'(SAT_HI) : ((rv[i] < SAT_LO) ? FW'(SAT_LO) : FW'(rv[i]));
      end
    end
  end

  assign result.out_x = ox[0];
  assign result.out_y = ox[1];
  assign result.out_z = ox[2];

endmodule

// File: rtl/core/vector_to_vector_rotator.sv
// ----------------------------------------------------------------------------
// vector_to_vector_rotator
// Rotates unit points by the rotation taking one configured vector onto the
// other.
// An accepted point passes the capture, product, sum and round registers.
// Throughput is one point per cycle while result beats are taken, set by the
// four-stage product pipeline. After reset or a vector register write the
// matrix rebuild is bounded by the serial square roots and divides (these are
// skipped for parallel vectors); no point is taken meanwhile.
// Reset loads both vectors with (1, 0, 0), which gives the identity rotation.
// ----------------------------------------------------------------------------
module vector_to_vector_rotator #(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  vvr_cfg_if.sink       cfg,
  vvr_point_if.sink     point,
  vvr_result_if.source  result
);

  localparam int FW = vvr_pkg::FIELD_W;
  localparam logic [FW-1:0] RESET_ONE = FW'(64'(1) << FRAC_BITS);

  logic signed [FW-1:0]         vec [vvr_pkg::NUM_REGS];
  logic                         go;
  logic                         mat_ok;
  logic signed [FRAC_BITS+2:0]  mat [9];
  logic                         wr;

  assign cfg.ready = 1'b1;
  assign wr = cfg.valid && cfg.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vec[vvr_pkg::REG_FROM_X] <= $signed(RESET_ONE);
      vec[vvr_pkg::REG_FROM_Y] <= '0;
      vec[vvr_pkg::REG_FROM_Z] <= '0;
      vec[vvr_pkg::REG_TO_X]   <= $signed(RESET_ONE);
      vec[vvr_pkg::REG_TO_Y]   <= '0;
      vec[vvr_pkg::REG_TO_Z]   <= '0;
      go                       <= 1'b1;
    end else begin
      go <= 1'b0;
      if (wr) begin
        unique case (cfg.index) inside
          vvr_pkg::REG_FROM_X, vvr_pkg::REG_FROM_Y, vvr_pkg::REG_FROM_Z,
          vvr_pkg::REG_TO_X, vvr_pkg::REG_TO_Y, vvr_pkg::REG_TO_Z: begin
            vec[cfg.index] <= $signed(cfg.data);
            go             <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  vvr_setup #(.FRAC_BITS(FRAC_BITS)) u_setup (
    .clk   (clk),
    .rst   (rst),
    .start (go),
    .vec   (vec),
    .ready (mat_ok),
    .mat   (mat)
  );

  vvr_datapath #(.FRAC_BITS(FRAC_BITS)) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .run    (mat_ok && !go),
    .mat    (mat),
    .point  (point),
    .result (result)
  );

  a_accept_needs_matrix: assert property (@(posedge clk) disable iff (rst)
    point.valid && point.ready |-> mat_ok)
    else $error("point taken while the matrix is being rebuilt");

  a_write_rebuilds: assert property (@(posedge clk) disable iff (rst)
    wr && (cfg.index == vvr_pkg::REG_FROM_X || cfg.index == vvr_pkg::REG_FROM_Y ||
           cfg.index == vvr_pkg::REG_FROM_Z || cfg.index == vvr_pkg::REG_TO_X ||
           cfg.index == vvr_pkg::REG_TO_Y || cfg.index == vvr_pkg::REG_TO_Z)
    |-> ##2 !mat_ok)
    else $error("register write did not start a matrix rebuild");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result.valid)
    else $error("result beat right after reset");

endmodule

// File: sim/vvr_rotation_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vvr_rotation_checker
// Watches the register, point and result channels of the rotator, keeps its
// own copy of the two vectors, predicts every rotated point and compares each
// result beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module vvr_rotation_checker #(
  parameter int FRAC_BITS = 16
) (
  input  logic   clk,
  input  logic   rst,
  vvr_cfg_if     cfg,
  vvr_point_if   point,
  vvr_result_if  result,
  output int     errors,
  output int     pending,
  output int     results_seen
);

  localparam int FIELD_W  = vvr_pkg::FIELD_W;
  localparam int NUM_REGS = vvr_pkg::NUM_REGS;

  typedef struct packed {
    logic signed [FIELD_W-1:0] x;
    logic signed [FIELD_W-1:0] y;
    logic signed [FIELD_W-1:0] z;
  } vec_t;

  logic signed [FIELD_W-1:0] vec_regs [NUM_REGS];
  vec_t rotated_q [$];

  function automatic longint round_frac(longint v, int sh);
    longint mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + (longint'(1) << (sh - 1))) >>> sh;
    return (v < 0) ? -mag : mag;
  endfunction

  function automatic longint fmul(longint a, longint b);
    return round_frac(a * b, FRAC_BITS);
  endfunction

  function automatic longint int_sqrt(longint n);
    longint res, bitv;
    res = 0;
    bitv = longint'(1) << 62;
    while (bitv > n) bitv = bitv >>> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - res - bitv;
        res = (res >>> 1) + bitv;
      end else begin
        res = res >>> 1;
      end
      bitv = bitv >>> 2;
    end
    return res;
  endfunction

  function automatic longint sat_unit(longint v);
    longint hi, lo, fmax;
    fmax = (longint'(1) << (FIELD_W - 1)) - 1;
    hi = longint'(1) << FRAC_BITS;
    lo = -hi;
    if (hi > fmax) hi = fmax;
    if (lo < -fmax - 1) lo = -fmax - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic vec_t rotate_point(vec_t p_in);
    longint one, c, s, t, m, mx, q;
    longint f [3], g [3], p [3], r [3], a [3], u [3], o [3], mat [9];
    vec_t res;
    one = longint'(1) << FRAC_BITS;
    for (int i = 0; i < 3; i++) begin
      f[i] = vec_regs[i];
      g[i] = vec_regs[3 + i];
    end
    p[0] = p_in.x;
    p[1] = p_in.y;
    p[2] = p_in.z;
    r[0] = f[2] * g[1] - f[1] * g[2];
    r[1] = f[0] * g[2] - f[2] * g[0];
    r[2] = f[1] * g[0] - f[0] * g[1];
    if (r[0] == 0 && r[1] == 0 && r[2] == 0) begin
      o = p;
    end else begin
      mx = 0;
      for (int i = 0; i < 3; i++) begin
        a[i] = (r[i] < 0) ? -r[i] : r[i];
        if (a[i] > mx) mx = a[i];
      end
      while (mx >= (longint'(1) << 30)) begin
        mx = mx >>> 1;
        for (int i = 0; i < 3; i++) a[i] = a[i] >>> 1;
      end
      while (mx < (longint'(1) << 29)) begin
        mx = mx << 1;
        for (int i = 0; i < 3; i++) a[i] = a[i] << 1;
      end
      m = int_sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
      for (int i = 0; i < 3; i++) begin
        q = (a[i] * one + m / 2) / m;
        if (q > one) q = one;
        u[i] = (r[i] < 0) ? -q : q;
      end
      c = round_frac(f[0] * g[0] + f[1] * g[1] + f[2] * g[2], FRAC_BITS);
      if (c > one) c = one;
      if (c < -one) c = -one;
      s = int_sqrt(one * one - c * c);
      t = one - c;
      mat[0] = c + fmul(fmul(u[0], u[0]), t);
      mat[1] = fmul(fmul(u[0], u[1]), t) + fmul(u[2], s);
      mat[2] = fmul(fmul(u[0], u[2]), t) - fmul(u[1], s);
      mat[3] = fmul(fmul(u[0], u[1]), t) - fmul(u[2], s);
      mat[4] = c + fmul(fmul(u[1], u[1]), t);
      mat[5] = fmul(u[0], s) + fmul(fmul(u[1], u[2]), t);
      mat[6] = fmul(fmul(u[0], u[2]), t) + fmul(u[1], s);
      mat[7] = -fmul(u[0], s) + fmul(fmul(u[1], u[2]), t);
      mat[8] = c + fmul(fmul(u[2], u[2]), t);
      for (int k = 0; k < 3; k++)
        o[k] = round_frac(mat[3*k] * p[0] + mat[3*k+1] * p[1] + mat[3*k+2] * p[2],
                          FRAC_BITS);
    end
    res.x = FIELD_W'(sat_unit(o[0]));
    res.y = FIELD_W'(sat_unit(o[1]));
    res.z = FIELD_W'(sat_unit(o[2]));
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  assign pending = rotated_q.size();

  always @(posedge clk) begin
    vec_t got, want;
    if (rst) begin
      vec_regs[vvr_pkg::REG_FROM_X] <= FIELD_W'(longint'(1) << FRAC_BITS);
      vec_regs[vvr_pkg::REG_FROM_Y] <= '0;
      vec_regs[vvr_pkg::REG_FROM_Z] <= '0;
      vec_regs[vvr_pkg::REG_TO_X] <= FIELD_W'(longint'(1) << FRAC_BITS);
      vec_regs[vvr_pkg::REG_TO_Y] <= '0;
      vec_regs[vvr_pkg::REG_TO_Z] <= '0;
      rotated_q.delete();
      errors <= 0;
      results_seen <= 0;
    end else begin
      if (cfg.valid && cfg.ready && cfg.index < NUM_REGS)
        vec_regs[cfg.index] <= cfg.data;
      if (point.valid && point.ready)
        rotated_q.insert(rotated_q.size(),
                         rotate_point('{point.in_x, point.in_y, point.in_z}));
      if (result.valid && result.ready) begin
        results_seen <= results_seen + 1;
        got = '{result.out_x, result.out_y, result.out_z};
        if (rotated_q.size() == 0) begin
          $display("%0t result beat with no point waiting", $realtime);
          errors++;
        end else begin
          want = rotated_q.pop_front();
          if (got.x !== want.x) report_mismatch("out_x", got.x, want.x);
          if (got.y !== want.y) report_mismatch("out_y", got.y, want.y);
          if (got.z !== want.z) report_mismatch("out_z", got.z, want.z);
        end
      end
    end
  end
endmodule

// File: sim/vector_to_vector_rotator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vector_to_vector_rotator_tb
// Drives vector pairs and point streams into the rotator with random gaps on
// both channels; the checker predicts and compares every rotated point.
// ----------------------------------------------------------------------------
module vector_to_vector_rotator_tb;

  localparam int ONE = 65536;
  localparam int FIELD_W = vvr_pkg::FIELD_W;
  localparam int CFG_IDX_W = vvr_pkg::CFG_IDX_W;

  logic clk;
  logic rst;
  int   errors, pending, results_seen;
  int   points_sent, settings_used;
  bit   sink_stall;

  vvr_cfg_if    cfg ();
  vvr_point_if  point ();
  vvr_result_if result ();

  vector_to_vector_rotator #(.FRAC_BITS(16)) uut (
    .clk(clk), .rst(rst), .cfg(cfg), .point(point), .result(result)
  );

  vvr_rotation_checker #(.FRAC_BITS(16)) u_checker (
    .clk(clk), .rst(rst), .cfg(cfg), .point(point), .result(result),
    .errors(errors), .pending(pending), .results_seen(results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Timed out with %0d results outstanding.", pending);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else if (sink_stall) begin
      result.ready <= ($urandom_range(0, 99) < 60);
    end else begin
      result.ready <= 1'b1;
    end
  end

  initial begin
    sink_stall = 1'b0;
    forever begin
      repeat ($urandom_range(50, 400)) @(posedge clk);
      sink_stall = ~sink_stall;
    end
  end

  function automatic logic [FIELD_W-1:0] rand_comp();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return FIELD_W'(ONE);
    if (r == 1) return FIELD_W'(-ONE);
    if (r == 2) return '0;
    if (r == 3) return FIELD_W'($urandom);
    return FIELD_W'($urandom_range(0, 2 * ONE) - ONE);
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [FIELD_W-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
  endtask

  task automatic set_vectors(logic [FIELD_W-1:0] fx, fy, fz, tx, ty, tz);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    write_reg(vvr_pkg::REG_FROM_X, fx);
    write_reg(vvr_pkg::REG_FROM_Y, fy);
    write_reg(vvr_pkg::REG_FROM_Z, fz);
    write_reg(vvr_pkg::REG_TO_X, tx);
    write_reg(vvr_pkg::REG_TO_Y, ty);
    write_reg(vvr_pkg::REG_TO_Z, tz);
    if ($urandom_range(0, 3) == 0)
      write_reg(CFG_IDX_W'(vvr_pkg::NUM_REGS + $urandom_range(0, 1)), '1);
    settings_used++;
  endtask

  task automatic send_point(logic [FIELD_W-1:0] x, y, z);
    int g;
    g = gap_len();
    if (g > 0) begin
      point.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    point.valid <= 1'b1;
    point.in_x <= x;
    point.in_y <= y;
    point.in_z <= z;
    do @(posedge clk); while (!point.ready);
    points_sent++;
  endtask

  task automatic send_batch(int n);
    for (int i = 0; i < n; i++) send_point(rand_comp(), rand_comp(), rand_comp());
    point.valid <= 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    cfg.valid <= 1'b0;
    cfg.index <= '0;
    cfg.data <= '0;
    point.valid <= 1'b0;
    point.in_x <= '0;
    point.in_y <= '0;
    point.in_z <= '0;
    points_sent = 0;
    settings_used = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_point(FIELD_W'(ONE), FIELD_W'(-ONE), '0);
    send_point(18'h1ffff, 18'h20000, 18'h3ffff);
    point.valid <= 1'b0;
    set_vectors(FIELD_W'(ONE), '0, '0, '0, FIELD_W'(ONE), '0);
    send_point(FIELD_W'(ONE), '0, '0);
    send_point('0, FIELD_W'(ONE), '0);
    send_point('0, '0, FIELD_W'(-ONE));
    send_point(18'h1ffff, 18'h1ffff, 18'h1ffff);
    send_point(18'h20000, 18'h20000, 18'h20000);
    point.valid <= 1'b0;
    set_vectors(FIELD_W'(ONE), '0, '0, FIELD_W'(-ONE), '0, '0);
    send_batch(3);
    set_vectors('0, '0, FIELD_W'(-ONE), '0, FIELD_W'(-ONE), '0);
    send_batch(3);
    set_vectors(18'h1ffff, 18'h20000, 18'd1, 18'h20000, 18'h1ffff, 18'h3ffff);
    send_batch(3);
    set_vectors('0, '0, '0, '0, '0, '0);
    send_batch(2);
    set_vectors(18'd46341, 18'd46341, '0, '0, '0, FIELD_W'(ONE));
    send_batch(3);

    while (points_sent < 1120) begin
      if ($urandom_range(0, 3) == 0)
        set_vectors(rand_comp(), rand_comp(), rand_comp(),
                    rand_comp(), rand_comp(), rand_comp());
      else
        set_vectors(FIELD_W'($urandom_range(0, 2 * ONE) - ONE),
                    FIELD_W'($urandom_range(0, 2 * ONE) - ONE),
                    FIELD_W'($urandom_range(0, 2 * ONE) - ONE),
                    FIELD_W'($urandom_range(0, 2 * ONE) - ONE),
                    FIELD_W'($urandom_range(0, 2 * ONE) - ONE),
                    FIELD_W'($urandom_range(0, 2 * ONE) - ONE));
      send_batch($urandom_range(20, 60));
    end

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Covered %0d points under %0d vector settings, %0d results checked.",
             points_sent, settings_used, results_seen);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
